FILE: rtl/keystroke_line_editor_core_macros.svh
// assertion macros shared by the checker
`ifndef KEYSTROKE_LINE_EDITOR_CORE_MACROS_SVH
`define KEYSTROKE_LINE_EDITOR_CORE_MACROS_SVH

// same-cycle implication, skipped while in reset
`define LCE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("line editor check failed");

// next-cycle implication, skipped while in reset
`define LCE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("line editor check failed");

`endif

FILE: rtl/lce_pkg.sv
`default_nettype none

package lce_pkg;

    localparam int LINE_DEPTH_DEF = 64;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [7:0] KEY_LEFT  = 8'h3C;
    localparam logic [7:0] KEY_RIGHT = 8'h3E;
    localparam logic [7:0] KEY_BACK  = 8'h2D;

    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_LEFT   = 3'd1;
    localparam logic [2:0] OP_RIGHT  = 3'd2;
    localparam logic [2:0] OP_BACK   = 3'd3;
    localparam logic [2:0] OP_EOL    = 3'd4;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] key;
    } lce_op_t;

endpackage

`default_nettype wire

FILE: rtl/keystroke_line_editor_core.sv
`default_nettype none

// Keystroke line editor. An item is taken when start is high and busy is low; items go
// into a four-entry queue, so busy rises only when that queue is full. The execution
// side takes an insert, a backspace or a move that does nothing in the idle state
// alone, a cursor move in a move state (memory read, then write to the other stack),
// and an end of line by popping it, then one result per stored character in the emit
// state. Results stream one per cycle with strobe high for that cycle only. The
// receiver cannot stall results: each one is lost if not captured while strobe is high.
// A line's first result passes the emit state and the output registers once its
// end-of-line item leaves the queue; an empty line's is registered in the cycle after.
// The block is ready right after reset; an insert into a line that already holds
// LINE_DEPTH characters is dropped, and every result of that line shows overflowed.

module keystroke_line_editor_core #(
    parameter int LINE_DEPTH = lce_pkg::LINE_DEPTH_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic       kind,
    input  wire logic [7:0] key,
    output logic            strobe,
    output logic [7:0]      out_char,
    output logic            line_empty,
    output logic            last_of_line,
    output logic            overflowed
);

    logic             q_valid;
    logic             q_pop;
    lce_pkg::lce_op_t q_head;

    lce_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .kind    (kind),
        .key     (key),
        .busy    (busy),
        .q_valid (q_valid),
        .q_head  (q_head),
        .q_pop   (q_pop)
    );

    lce_back #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .strobe       (strobe),
        .out_char     (out_char),
        .line_empty   (line_empty),
        .last_of_line (last_of_line),
        .overflowed   (overflowed)
    );

endmodule

`default_nettype wire

FILE: rtl/lce_front.sv
`default_nettype none

module lce_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire logic            kind,
    input  wire logic [7:0]      key,
    output logic                 busy,
    output logic                 q_valid,
    output lce_pkg::lce_op_t     q_head,
    input  wire logic            q_pop
);

    localparam int PW  = (lce_pkg::QUEUE_DEPTH > 1) ? $clog2(lce_pkg::QUEUE_DEPTH) : 1;
    localparam int CNW = $clog2(lce_pkg::QUEUE_DEPTH + 1);

    lce_pkg::lce_op_t q_mem [lce_pkg::QUEUE_DEPTH];

    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNW-1:0] count_reg, count_next;

    lce_pkg::lce_op_t item;
    logic             push;

    // classify the keystroke
    always_comb
    begin
        item.key = key;
        item.op  = lce_pkg::OP_INSERT;
        if (kind)
        begin
            item.op = lce_pkg::OP_EOL;
        end
        else
        begin
            case (key)
                lce_pkg::KEY_LEFT:  item.op = lce_pkg::OP_LEFT;
                lce_pkg::KEY_RIGHT: item.op = lce_pkg::OP_RIGHT;
                lce_pkg::KEY_BACK:  item.op = lce_pkg::OP_BACK;
                default:            item.op = lce_pkg::OP_INSERT;
            endcase
        end
    end

    assign busy    = (count_reg == CNW'(lce_pkg::QUEUE_DEPTH));
    assign push    = start && !busy;
    assign q_valid = (count_reg != '0);
    assign q_head  = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(lce_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                        : wr_ptr_reg + 1'b1;
        end
        if (q_pop && q_valid)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(lce_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                        : rd_ptr_reg + 1'b1;
        end
        if (push && !(q_pop && q_valid))
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && q_pop && q_valid)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= item;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/lce_back.sv
`default_nettype none

module lce_back #(
    parameter int LINE_DEPTH = lce_pkg::LINE_DEPTH_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             q_valid,
    input  wire lce_pkg::lce_op_t q_head,
    output logic                  q_pop,
    output logic                  strobe,
    output logic [7:0]            out_char,
    output logic                  line_empty,
    output logic                  last_of_line,
    output logic                  overflowed
);

    localparam int AW = $clog2(LINE_DEPTH);
    localparam int CW = $clog2(LINE_DEPTH + 1);
    localparam int TW = CW + 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(LINE_DEPTH);
    localparam logic [TW-1:0] DEPTH_T = TW'(LINE_DEPTH);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_LEFT  = 2'd1;
    localparam logic [1:0] ST_RIGHT = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [7:0] before_mem [LINE_DEPTH];
    logic [7:0] after_mem  [LINE_DEPTH];

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] bc_reg, bc_next;
    logic [CW-1:0] ac_reg, ac_next;
    logic          drop_reg, drop_next;
    logic [CW-1:0] k_reg, k_next;

    logic          out_valid_reg, out_valid_next;
    logic          out_empty_reg, out_empty_next;
    logic          out_last_reg, out_last_next;
    logic          out_src_reg, out_src_next;
    logic          out_ovf_reg, out_ovf_next;

    logic [7:0]    rd_b_reg, rd_a_reg;

    logic          b_we, a_we;
    logic [AW-1:0] b_waddr, a_waddr, b_raddr, a_raddr;
    logic [7:0]    b_wdata, a_wdata;

    logic [TW-1:0] total;
    logic [CW-1:0] bc_dec, ac_dec;
    logic [TW-1:0] after_idx;
    logic          is_last;

    assign total     = TW'(bc_reg) + TW'(ac_reg);
    assign bc_dec    = bc_reg - CW'(1);
    assign ac_dec    = ac_reg - CW'(1);
    // the after stack is read from its top down
    assign after_idx = total - TW'(k_reg) - TW'(1);
    assign is_last   = ((TW'(k_reg) + TW'(1)) == total);

    always_comb
    begin
        state_next     = state_reg;
        bc_next        = bc_reg;
        ac_next        = ac_reg;
        drop_next      = drop_reg;
        k_next         = k_reg;
        out_valid_next = 1'b0;
        out_empty_next = 1'b0;
        out_last_next  = 1'b0;
        out_src_next   = 1'b0;
        out_ovf_next   = drop_reg;
        q_pop          = 1'b0;
        b_we           = 1'b0;
        a_we           = 1'b0;
        b_waddr        = bc_reg[AW-1:0];
        a_waddr        = ac_reg[AW-1:0];
        b_wdata        = q_head.key;
        a_wdata        = rd_b_reg;
        b_raddr        = k_reg[AW-1:0];
        a_raddr        = after_idx[AW-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    case (q_head.op)
                        lce_pkg::OP_INSERT:
                        begin
                            if (total >= DEPTH_T)
                            begin
                                drop_next = 1'b1;
                            end
                            else
                            begin
                                b_we    = 1'b1;
                                bc_next = bc_reg + 1'b1;
                            end
                        end
                        lce_pkg::OP_BACK:
                        begin
                            if (bc_reg != '0)
                            begin
                                bc_next = bc_dec;
                            end
                        end
                        lce_pkg::OP_LEFT:
                        begin
                            if (bc_reg != '0 && ac_reg < DEPTH_C)
                            begin
                                b_raddr    = bc_dec[AW-1:0];
                                state_next = ST_LEFT;
                            end
                        end
                        lce_pkg::OP_RIGHT:
                        begin
                            if (ac_reg != '0 && bc_reg < DEPTH_C)
                            begin
                                a_raddr    = ac_dec[AW-1:0];
                                state_next = ST_RIGHT;
                            end
                        end
                        lce_pkg::OP_EOL:
                        begin
                            if (total == '0)
                            begin
                                out_valid_next = 1'b1;
                                out_empty_next = 1'b1;
                                out_last_next  = 1'b1;
                                drop_next      = 1'b0;
                            end
                            else
                            begin
                                k_next     = '0;
                                state_next = ST_EMIT;
                            end
                        end
                        default:
                        begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_LEFT:
            begin
                a_we       = 1'b1;
                a_wdata    = rd_b_reg;
                ac_next    = ac_reg + 1'b1;
                bc_next    = bc_dec;
                state_next = ST_IDLE;
            end
            ST_RIGHT:
            begin
                b_we       = 1'b1;
                b_wdata    = rd_a_reg;
                bc_next    = bc_reg + 1'b1;
                ac_next    = ac_dec;
                state_next = ST_IDLE;
            end
            ST_EMIT:
            begin
                out_valid_next = 1'b1;
                out_last_next  = is_last;
                out_src_next   = (k_reg >= bc_reg);
                k_next         = k_reg + 1'b1;
                if (is_last)
                begin
                    bc_next    = '0;
                    ac_next    = '0;
                    drop_next  = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bc_reg        <= '0;
            ac_reg        <= '0;
            drop_reg      <= 1'b0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
            out_empty_reg <= 1'b0;
            out_last_reg  <= 1'b0;
            out_src_reg   <= 1'b0;
            out_ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bc_reg        <= bc_next;
            ac_reg        <= ac_next;
            drop_reg      <= drop_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
            out_empty_reg <= out_empty_next;
            out_last_reg  <= out_last_next;
            out_src_reg   <= out_src_next;
            out_ovf_reg   <= out_ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_we)
        begin
            before_mem[b_waddr] <= b_wdata;
        end
        rd_b_reg <= before_mem[b_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (a_we)
        begin
            after_mem[a_waddr] <= a_wdata;
        end
        rd_a_reg <= after_mem[a_raddr];
    end

    assign strobe       = out_valid_reg;
    assign line_empty   = out_empty_reg;
    assign last_of_line = out_last_reg;
    assign overflowed   = out_ovf_reg;
    assign out_char     = out_empty_reg ? 8'h00 : (out_src_reg ? rd_a_reg : rd_b_reg);

endmodule

`default_nettype wire

FILE: rtl/lce_checker.sv
`default_nettype none

`include "keystroke_line_editor_core_macros.svh"

module lce_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       kind,
    input wire logic [7:0] key,
    input wire logic       strobe,
    input wire logic [7:0] out_char,
    input wire logic       line_empty,
    input wire logic       last_of_line,
    input wire logic       overflowed
);

    // an empty line is a single result
    `LCE_ASSERT_NOW(a_empty_is_last, clk, rst_n, strobe && line_empty, last_of_line)
    `LCE_ASSERT_NOW(a_empty_char_zero, clk, rst_n, strobe && line_empty, out_char == 8'h00)
    // a line streams without gaps
    `LCE_ASSERT_NEXT(a_line_contiguous, clk, rst_n, strobe && !last_of_line, strobe)
    `LCE_ASSERT_NEXT(a_ovf_steady, clk, rst_n, strobe && !last_of_line, $stable(overflowed))

endmodule

bind keystroke_line_editor_core lce_checker u_checker (.*);

`default_nettype wire

FILE: bench/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int DEPTH = lce_pkg::LINE_DEPTH_DEF;
    localparam logic KIND_KEY = 1'b0;
    localparam logic KIND_EOL = 1'b1;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 2 * DEPTH + 20;

    typedef struct packed {
        logic [7:0] ch;
        logic       empty;
        logic       is_last;
        logic       ovf;
    } line_result_t;

    class line_editor_model;
        logic [7:0]   before_stack [DEPTH];
        logic [7:0]   after_stack [DEPTH];
        int           n_before;
        int           n_after;
        logic         dropped;
        line_result_t pending_chars [$];
        int           mismatch_count;
        int           n_lines;
        int           n_overflow_lines;
        int           n_checked;

        function new();
            n_before = 0;
            n_after = 0;
            dropped = 1'b0;
            mismatch_count = 0;
            n_lines = 0;
            n_overflow_lines = 0;
            n_checked = 0;
        endfunction

        task report_mismatch(input string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            mismatch_count++;
        endtask

        // called on every accepted transfer into the block
        function void note_keystroke(input logic k, input logic [7:0] ky);
            int total;
            int idx;
            if (k == KIND_KEY)
            begin
                case (ky)
                    lce_pkg::KEY_LEFT:
                        if (n_before > 0 && n_after < DEPTH)
                        begin
                            n_before--;
                            after_stack[n_after] = before_stack[n_before];
                            n_after++;
                        end
                    lce_pkg::KEY_RIGHT:
                        if (n_after > 0 && n_before < DEPTH)
                        begin
                            n_after--;
                            before_stack[n_before] = after_stack[n_after];
                            n_before++;
                        end
                    lce_pkg::KEY_BACK:
                        if (n_before > 0)
                            n_before--;
                    default:
                        if (n_before + n_after >= DEPTH)
                            dropped = 1'b1;
                        else
                        begin
                            before_stack[n_before] = ky;
                            n_before++;
                        end
                endcase
            end
            else
            begin
                total = n_before + n_after;
                n_lines++;
                if (dropped)
                    n_overflow_lines++;
                if (total == 0)
                    pending_chars.push_back('{8'h00, 1'b1, 1'b1, dropped});
                else
                begin
                    idx = 0;
                    for (int i = 0; i < n_before; i++)
                    begin
                        pending_chars.push_back('{before_stack[i], 1'b0,
                                                  idx + 1 == total, dropped});
                        idx++;
                    end
                    // the right-hand stack reads out from its top down
                    for (int i = n_after; i > 0; i--)
                    begin
                        pending_chars.push_back('{after_stack[i - 1], 1'b0,
                                                  idx + 1 == total, dropped});
                        idx++;
                    end
                end
                n_before = 0;
                n_after = 0;
                dropped = 1'b0;
            end
        endfunction

        task check_emitted(input line_result_t got);
            line_result_t want;
            if (pending_chars.size() == 0)
            begin
                report_mismatch($sformatf("result with nothing pending, char %02h", got.ch));
            end
            else
            begin
                want = pending_chars.pop_front();
                n_checked++;
                if (got.ch !== want.ch)
                    report_mismatch($sformatf("out_char %02h, wanted %02h", got.ch, want.ch));
                if (got.empty !== want.empty)
                    report_mismatch($sformatf("line_empty %b, wanted %b",
                                              got.empty, want.empty));
                if (got.is_last !== want.is_last)
                    report_mismatch($sformatf("last_of_line %b, wanted %b",
                                              got.is_last, want.is_last));
                if (got.ovf !== want.ovf)
                    report_mismatch($sformatf("overflowed %b, wanted %b", got.ovf, want.ovf));
            end
        endtask
    endclass

    logic       clk = 1'b0;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic       kind;
    logic [7:0] key;
    logic       strobe;
    logic [7:0] out_char;
    logic       line_empty;
    logic       last_of_line;
    logic       overflowed;

    line_editor_model editor_model = new();
    int  items_sent;
    int  items_taken;
    int  quiet_cycles;
    bit  no_idle;

    always #4 clk = ~clk;

    keystroke_line_editor_core #(
        .LINE_DEPTH(DEPTH)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .kind(kind),
        .key(key),
        .strobe(strobe),
        .out_char(out_char),
        .line_empty(line_empty),
        .last_of_line(last_of_line),
        .overflowed(overflowed)
    );

    // sample both sides at the edge; values seen here are the pre-edge ones
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || strobe)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (start && !busy)
            begin
                editor_model.note_keystroke(kind, key);
                items_taken++;
            end
            if (strobe)
                editor_model.check_emitted('{out_char, line_empty, last_of_line, overflowed});
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // fill lines lean heavily on inserts so the buffer runs full
    function automatic logic [7:0] pick_key(input bit fill);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < (fill ? 85 : 55))
            return 8'($urandom_range(0, 255));
        else if (r < (fill ? 90 : 70))
            return lce_pkg::KEY_LEFT;
        else if (r < (fill ? 95 : 85))
            return lce_pkg::KEY_RIGHT;
        else
            return lce_pkg::KEY_BACK;
    endfunction

    task automatic send_item(input logic k, input logic [7:0] ky);
        int gap;
        start <= 1'b1;
        kind <= k;
        key <= ky;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_line(input bit fill);
        int line_len;
        line_len = fill ? $urandom_range(88, 95) : $urandom_range(0, 10);
        no_idle = ($urandom_range(0, 9) < 3);
        repeat (line_len) send_item(KIND_KEY, pick_key(fill));
        send_item(KIND_EOL, 8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        int random_start;
        int n_random_lines;
        rst_n = 1'b0;
        start = 1'b0;
        kind = KIND_KEY;
        key = 8'h00;
        items_sent = 0;
        items_taken = 0;
        quiet_cycles = 0;
        no_idle = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty lines, key ignored on end of line
        send_item(KIND_EOL, 8'h00);
        send_item(KIND_EOL, 8'hFF);
        // moves and delete with nothing stored
        send_item(KIND_KEY, lce_pkg::KEY_LEFT);
        send_item(KIND_KEY, lce_pkg::KEY_RIGHT);
        send_item(KIND_KEY, lce_pkg::KEY_BACK);
        send_item(KIND_EOL, lce_pkg::KEY_BACK);
        // single character line
        send_item(KIND_KEY, 8'h78);
        send_item(KIND_EOL, 8'h00);
        // extreme bytes, edits in the middle, moves past both ends
        send_item(KIND_KEY, 8'h00);
        send_item(KIND_KEY, 8'hFF);
        send_item(KIND_KEY, 8'h41);
        send_item(KIND_KEY, lce_pkg::KEY_LEFT);
        send_item(KIND_KEY, lce_pkg::KEY_LEFT);
        send_item(KIND_KEY, 8'h7E);
        send_item(KIND_KEY, lce_pkg::KEY_RIGHT);
        send_item(KIND_KEY, lce_pkg::KEY_BACK);
        send_item(KIND_KEY, lce_pkg::KEY_RIGHT);
        send_item(KIND_KEY, lce_pkg::KEY_RIGHT);
        send_item(KIND_KEY, lce_pkg::KEY_LEFT);
        send_item(KIND_KEY, lce_pkg::KEY_LEFT);
        send_item(KIND_KEY, lce_pkg::KEY_LEFT);
        send_item(KIND_KEY, lce_pkg::KEY_LEFT);
        send_item(KIND_EOL, lce_pkg::KEY_LEFT);

        // one short line, then one fill line that overruns the buffer
        random_start = items_sent;
        n_random_lines = 0;
        while (items_sent - random_start < 87 || n_random_lines < 2)
        begin
            send_line(n_random_lines == 1);
            n_random_lines++;
        end
        start <= 1'b0;

        while (editor_model.pending_chars.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (editor_model.pending_chars.size() != 0)
            editor_model.report_mismatch($sformatf("%0d results never arrived",
                                                   editor_model.pending_chars.size()));

        $display("covered %0d transfers in, %0d lines out (%0d with dropped inserts)",
                 items_taken, editor_model.n_lines, editor_model.n_overflow_lines);
        $display("checked %0d characters, %0d mismatches",
                 editor_model.n_checked, editor_model.mismatch_count);
        if (editor_model.mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
